### rtl/vpt_pkg.sv
// Shared constants and types of the vertex perspective transform.
package vpt_pkg;

	// Fixed-point format and datapath widths.
	localparam int FRAC_BITS = 16;
	localparam int Q_W       = 32;
	localparam int PROD_W    = 2 * Q_W;
	localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
	localparam int MAG_W     = SUM_W;

	// Divider layout: quotient bits resolved per stage and stage count.
	localparam int DIV_PER = 2;
	localparam int DIV_ST  = Q_W / DIV_PER;

	// Pipeline stage numbers.
	localparam int ST_MUL  = 1;
	localparam int ST_SUM  = 2;
	localparam int ST_ABS  = 3;
	localparam int ST_FIN  = ST_ABS + DIV_ST + 1;
	localparam int NUM_ST  = ST_FIN;

	// Configuration register file.
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = REG_IDX_W + 3;
	localparam int REG_W     = 64;
	localparam logic [REG_W-1:0] ONE_Q = REG_W'(1) << FRAC_BITS;
	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		ONE_Q << Q_W, '0, ONE_Q, '0, '0, ONE_Q << Q_W, '0, ONE_Q
	};

	typedef logic signed [Q_W-1:0] coord_t;
	typedef logic [3:0][3:0][Q_W-1:0] mat_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [NUM_ST:1] stage_en_t;

endpackage

### rtl/vpt_if.sv
// Valid/ready channel interfaces for vertex beats and result beats.
interface vpt_vtx_if;
	import vpt_pkg::*;
	logic   valid;
	logic   ready;
	coord_t in_x;
	coord_t in_y;
	coord_t in_z;
	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface vpt_res_if;
	import vpt_pkg::*;
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   w_zero;
	logic   overflow;
	modport source (output valid, out_x, out_y, out_z, w_zero, overflow, input ready);
	modport sink (input valid, out_x, out_y, out_z, w_zero, overflow, output ready);
endinterface

### rtl/vpt_regs.sv
// APB register file holding the 4x4 transform matrix.
module vpt_regs import vpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output mat_t              mat
);

	logic [REG_W-1:0]     regs_q [NUM_REGS];
	logic [REG_IDX_W-1:0] idx;

	assign idx = paddr[ADDR_W-1:3];

	// Registers are written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= REG_RESET[i];
		end else if (psel && penable && pwrite) begin
			regs_q[idx] <= pwdata;
		end
	end

	assign prdata = regs_q[idx];

	// Each row spans two registers, upper half first.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = regs_q[2*r][REG_W-1:Q_W];
			mat[r][1] = regs_q[2*r][Q_W-1:0];
			mat[r][2] = regs_q[2*r+1][REG_W-1:Q_W];
			mat[r][3] = regs_q[2*r+1][Q_W-1:0];
		end
	end

endmodule

### rtl/vpt_mac.sv
// Matrix-vector product: one multiply stage and one sum stage.
module vpt_mac import vpt_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  coord_t    x,
	input  coord_t    y,
	input  coord_t    z,
	input  mat_t      mat,
	output sum_t      t_s2 [4]
);

	logic signed [PROD_W-1:0] prod_s1 [4][3];
	coord_t                   vin [3];

	assign vin[0] = x;
	assign vin[1] = y;
	assign vin[2] = z;

	// Twelve exact products, one multiplier each.
	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= PROD_W'(vin[c]) * PROD_W'($signed(mat[r][c]));
		end
	end

	// Floor-shifted products plus the translation entry of each row.
	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			for (int r = 0; r < 4; r++)
				t_s2[r] <= SUM_W'(prod_s1[r][0] >>> FRAC_BITS)
					+ SUM_W'(prod_s1[r][1] >>> FRAC_BITS)
					+ SUM_W'(prod_s1[r][2] >>> FRAC_BITS)
					+ SUM_W'($signed(mat[r][3]));
		end
	end

endmodule

### rtl/vpt_div.sv
// One lane of the pipelined saturating divider n * 2^FRAC_BITS / w.
module vpt_div import vpt_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  sum_t      n,
	input  sum_t      w,
	output coord_t    q_fin,
	output logic      ovf_fin
);

	logic [MAG_W-1:0] an_s3, aw_s3;
	logic             neg_s3;

	logic [MAG_W-1:0] rem_s [DIV_ST];
	logic [MAG_W-1:0] aw_s  [DIV_ST];
	logic [Q_W-1:0]   dlo_s [DIV_ST];
	logic [Q_W-1:0]   quo_s [DIV_ST];
	logic             neg_s [DIV_ST];
	logic             ovf_s [DIV_ST];

	logic [MAG_W-1:0] rem_init;

	// Magnitudes and result sign.
	always_ff @(posedge clk) begin
		if (en[ST_ABS]) begin
			an_s3  <= n[SUM_W-1] ? MAG_W'(-n) : MAG_W'(n);
			aw_s3  <= w[SUM_W-1] ? MAG_W'(-w) : MAG_W'(w);
			neg_s3 <= n[SUM_W-1] ^ w[SUM_W-1];
		end
	end

	// The integer part must stay below 2^(32-FRAC_BITS) or the quotient overflows.
	assign rem_init = an_s3 >> (Q_W - FRAC_BITS);

	for (genvar j = 0; j < DIV_ST; j++) begin : g_step
		logic [MAG_W-1:0] r_in, a_in;
		logic [Q_W-1:0]   d_in, q_in;
		logic             n_in, o_in;
		logic [MAG_W-1:0] r_nx;
		logic [Q_W-1:0]   d_nx, q_nx;

		if (j == 0) begin : g_first
			assign r_in = rem_init;
			assign a_in = aw_s3;
			assign d_in = {an_s3[Q_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			assign q_in = '0;
			assign n_in = neg_s3;
			assign o_in = (rem_init >= aw_s3);
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign a_in = aw_s[j-1];
			assign d_in = dlo_s[j-1];
			assign q_in = quo_s[j-1];
			assign n_in = neg_s[j-1];
			assign o_in = ovf_s[j-1];
		end

		// Restoring division, DIV_PER quotient bits per stage.
		always_comb begin
			logic [MAG_W:0] t;
			r_nx = r_in;
			d_nx = d_in;
			q_nx = q_in;
			for (int k = 0; k < DIV_PER; k++) begin
				t    = {r_nx, d_nx[Q_W-1]};
				d_nx = d_nx << 1;
				if (t >= {1'b0, a_in}) begin
					t    = t - {1'b0, a_in};
					q_nx = {q_nx[Q_W-2:0], 1'b1};
				end else begin
					q_nx = {q_nx[Q_W-2:0], 1'b0};
				end
				r_nx = t[MAG_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_ABS+1+j]) begin
				rem_s[j] <= r_nx;
				aw_s[j]  <= a_in;
				dlo_s[j] <= d_nx;
				quo_s[j] <= q_nx;
				neg_s[j] <= n_in;
				ovf_s[j] <= o_in;
			end
		end
	end

	// Saturate to the signed range and apply the sign.
	logic [Q_W-1:0] lim, mag;
	logic           sat;

	always_comb begin
		lim = {neg_s[DIV_ST-1], {(Q_W-1){~neg_s[DIV_ST-1]}}};
		sat = ovf_s[DIV_ST-1] || (quo_s[DIV_ST-1] > lim);
		mag = sat ? lim : quo_s[DIV_ST-1];
	end

	always_ff @(posedge clk) begin
		if (en[ST_FIN]) begin
			q_fin   <= neg_s[DIV_ST-1] ? -mag : mag;
			ovf_fin <= sat;
		end
	end

endmodule

### rtl/vertex_perspective_transform_unit.sv
// Top level of the vertex perspective transform pipeline.
//
//   channel  dir  handshake      payload
//   vtx      in   valid/ready    in_x, in_y, in_z (Q16.16)
//   res      out  valid/ready    out_x, out_y, out_z, w_zero, overflow
//   apb      in   psel/penable   paddr, pwdata, prdata (64-bit matrix registers)
//
// A vertex passes 20 register stages: one multiply stage, one sum stage, one
// magnitude stage, 16 divider stages resolving two quotient bits each, and one
// saturation stage that is the output register. One vertex is accepted per
// cycle unless a stall at the output has backed up to the first stage. Each
// stage holds only when it is full and the stage after it cannot take its beat,
// so bubbles close up under a stall.
// Reset clears all valid bits and loads the identity matrix.
module vertex_perspective_transform_unit import vpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	vpt_vtx_if.sink           vtx,
	vpt_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready
);

	mat_t      mat;
	stage_en_t en;
	logic      vld_s [1:NUM_ST];
	logic      wz_s  [ST_ABS:NUM_ST];
	sum_t      t_s2  [4];
	coord_t    q_fin [3];
	logic      o_fin [3];

	assign pready = 1'b1;

	vpt_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .mat
	);

	// Stage enables: a stage loads when empty or when its beat moves on.
	always_comb begin
		en[NUM_ST] = !vld_s[NUM_ST] || res.ready;
		for (int k = NUM_ST - 1; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign vtx.ready = en[1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NUM_ST; k++) vld_s[k] <= 1'b0;
		end else begin
			if (en[1]) vld_s[1] <= vtx.valid;
			for (int k = 2; k <= NUM_ST; k++)
				if (en[k]) vld_s[k] <= vld_s[k-1];
		end
	end

	vpt_mac u_mac (
		.clk, .en, .x(vtx.in_x), .y(vtx.in_y), .z(vtx.in_z), .mat, .t_s2
	);

	// Zero-w flag follows the divider stages.
	always_ff @(posedge clk) begin
		if (en[ST_ABS]) wz_s[ST_ABS] <= (t_s2[3] == '0);
		for (int k = ST_ABS + 1; k <= NUM_ST; k++)
			if (en[k]) wz_s[k] <= wz_s[k-1];
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vpt_div u_div (
			.clk, .en, .n(t_s2[i]), .w(t_s2[3]), .q_fin(q_fin[i]), .ovf_fin(o_fin[i])
		);
	end

	// Result beat; a zero w forces zero coordinates and no overflow.
	assign res.valid    = vld_s[NUM_ST];
	assign res.out_x    = wz_s[NUM_ST] ? '0 : q_fin[0];
	assign res.out_y    = wz_s[NUM_ST] ? '0 : q_fin[1];
	assign res.out_z    = wz_s[NUM_ST] ? '0 : q_fin[2];
	assign res.w_zero   = wz_s[NUM_ST];
	assign res.overflow = !wz_s[NUM_ST] && (o_fin[0] || o_fin[1] || o_fin[2]);

	// An empty output stage always lets a vertex in.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NUM_ST] |-> vtx.ready)
		else $error("input stalled with an empty output stage");

	// A zero-w result carries zero coordinates and no overflow.
	a_wzero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.w_zero |-> res.out_x == '0 && res.out_y == '0
			&& res.out_z == '0 && !res.overflow)
		else $error("zero-w result not cleared");

	// Overflow means some coordinate sits at a saturation limit.
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.overflow |->
			res.out_x == 32'sh7fffffff || res.out_x == 32'sh80000000 ||
			res.out_y == 32'sh7fffffff || res.out_y == 32'sh80000000 ||
			res.out_z == 32'sh7fffffff || res.out_z == 32'sh80000000)
		else $error("overflow without a saturated coordinate");

	// The stalled full stage before the output stage keeps its beat.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NUM_ST-1] && !en[NUM_ST-1] |=> vld_s[NUM_ST-1])
		else $error("beat dropped in a stalled stage");

endmodule
